>>> rtl/depth_hypothesis_stack_fusion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth hypothesis stack
// Shared helpers for concurrent checks, clocked on rising edge, reset low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_HYPOTHESIS_STACK_FUSION_DEFINES_SVH
`define DEPTH_HYPOTHESIS_STACK_FUSION_DEFINES_SVH

// Same-cycle implication.
`define HDSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HDSF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hdsf_pkg.sv
// ----------------------------------------------------------------------------
// hdsf_pkg
// Types, constants and codes of the depth hypothesis stack.
// ----------------------------------------------------------------------------
`default_nettype none

package hdsf_pkg;

  localparam int MAP_WIDTH  = 128;
  localparam int MAP_HEIGHT = 128;
  localparam int HYP_DEPTH  = 4;

  localparam int ROWS   = MAP_WIDTH * MAP_HEIGHT;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int HW     = (HYP_DEPTH > 1) ? $clog2(HYP_DEPTH) : 1;

  localparam int DW    = 24;
  localparam int CW    = 16;
  localparam int NUM_W = 2 * DW + 1;
  localparam int DEN_W = DW + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] OP_FUSE   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [2:0] CFG_MIN_DEPTH     = 3'd0;
  localparam logic [2:0] CFG_COST_STEP     = 3'd1;
  localparam logic [2:0] CFG_DEFAULT_COST  = 3'd2;
  localparam logic [2:0] CFG_DEFAULT_SIGMA = 3'd3;
  localparam logic [2:0] CFG_REJECT_THR    = 3'd4;

  typedef struct packed {
    logic [DW-1:0] d;
    logic [DW-1:0] v;
    logic [CW-1:0] c;
  } hyp_t;

  typedef hyp_t [HYP_DEPTH-1:0] row_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CAP, S_WALK, S_MUL0, S_MUL1, S_MUL2,
    S_DIV0S, S_DIV0W, S_DIV1S, S_DIV1W, S_SORT, S_WB, S_SW_RD, S_SW_WR
  } state_e;

endpackage

`default_nettype wire

>>> rtl/hdsf_if.sv
// ----------------------------------------------------------------------------
// hdsf_if
// Request, result and configuration channels of the hypothesis stack.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdsf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  pix_x;
  logic [7:0]  pix_y;
  logic [2:0]  hyp_slot;
  logic [23:0] meas_depth;
  logic [23:0] meas_var;
  modport source (output valid, op, pix_x, pix_y, hyp_slot, meas_depth, meas_var,
                  input ready);
  modport sink (input valid, op, pix_x, pix_y, hyp_slot, meas_depth, meas_var,
                output ready);
endinterface

interface hdsf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] read_depth;
  logic [23:0] read_var;
  logic [15:0] read_cost;
  modport source (output valid, status, read_depth, read_var, read_cost, input ready);
  modport sink (input valid, status, read_depth, read_var, read_cost, output ready);
endinterface

interface hdsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/hdsf_ram.sv
// ----------------------------------------------------------------------------
// hdsf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsf_ram #(
  parameter int DW = 256,
  parameter int AW = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/hdsf_div.sv
// ----------------------------------------------------------------------------
// hdsf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hdsf_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [hdsf_pkg::NUM_W-1:0] num_i,
  input  wire logic [hdsf_pkg::DEN_W-1:0] den_i,
  output hdsf_pkg::div_res_t             res_o
);
  import hdsf_pkg::*;

  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]     n_q, n_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W:0]       rem_q, rem_d;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], n_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_W);
      n_d    = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      n_d   = {n_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign res_o.done = done_q;
  assign res_o.quo  = n_q;

endmodule

`default_nettype wire

>>> rtl/depth_hypothesis_stack_fusion.sv
// ----------------------------------------------------------------------------
// depth_hypothesis_stack_fusion
// Per-pixel depth hypothesis stack with measurement fusion and rejection.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass writes every pixel row
// of the store before the first request is taken. A fuse request reads the
// row, captures it, walks up to four slots, runs six compare-swap steps and
// writes back; when a slot is fused it adds three passes through the shared
// 24x24 multiplier and two 49-step divisions. A read reads and captures the
// row; a rejection sweep reads and writes every pixel row through the single
// memory port pair. A finished result waits in the output register, and the
// next request is taken only once that register is free or being read.
`default_nettype none
`include "depth_hypothesis_stack_fusion_defines.svh"

module depth_hypothesis_stack_fusion (
  input wire logic clk_i,
  input wire logic rst_ni,
  hdsf_in_if.sink     in_i,
  hdsf_out_if.source  out_o,
  hdsf_cfg_if.sink    cfg_i
);
  import hdsf_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [DW-1:0] min_depth_q, dsigma_q;
  logic [CW-1:0] step_q, dcost_q, thr_q;

  // request and working registers
  logic [1:0]        op_q, status_q;
  logic [HW-1:0]     slot_q, h_q, i_q, j_q;
  logic [DW-1:0]     md_q, mv_q;
  logic [ROW_AW-1:0] row_q, cnt_q;
  logic              matched_q;
  row_t              stk_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  num_q;
  logic [2*DW-1:0]   prod_q;
  hyp_t              res_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  hyp_t              out_hyp_q;

  // memory and units
  logic              mem_we, mem_re;
  logic [ROW_AW-1:0] mem_waddr, mem_raddr;
  row_t              mem_wdata, mem_rdata, swept;
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  div_res_t          div_res;
  logic [DW-1:0]     mul_a, mul_b;

  // request decode
  logic              in_acc, in_start, on_map, slot_ok, out_free;
  logic [ROW_AW-1:0] in_row;
  hyp_t              cur, sa, sb, last;
  row_t              cap_stk, sort_stk;
  logic [DW-1:0]     delta;
  logic [DEN_W-1:0]  den;
  logic              is_match, sort_swap, h_last, sort_last, push_skip;
  logic [CW:0]       cost_inc, dec;
  logic [CW-1:0]     cost_sat, cost_dec;
  logic [CW+1:0]     push_sum;
  logic [CW-1:0]     push_cost;

  hdsf_ram #(.DW($bits(row_t)), .AW(ROW_AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hdsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .res_o   (div_res)
  );

  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_start    = in_acc && (state_d != S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign on_map      = ({1'b0, in_i.pix_x} < 9'(MAP_WIDTH)) &&
                       ({1'b0, in_i.pix_y} < 9'(MAP_HEIGHT));
  assign slot_ok     = {1'b0, in_i.hyp_slot} < 4'(HYP_DEPTH);
  assign in_row      = ROW_AW'(32'(in_i.pix_y) * MAP_WIDTH + 32'(in_i.pix_x));

  always_comb begin
    cur       = stk_q[h_q];
    sa        = stk_q[i_q];
    sb        = stk_q[j_q];
    last      = mem_rdata[HYP_DEPTH-1];
    delta     = (cur.d > md_q) ? cur.d - md_q : md_q - cur.d;
    den       = {1'b0, cur.v} + {1'b0, mv_q};
    is_match  = !matched_q && ((delta < cur.v) || (delta < mv_q));
    cost_inc  = {1'b0, cur.c} + {1'b0, step_q};
    cost_sat  = cost_inc[CW] ? '1 : cost_inc[CW-1:0];
    dec       = {step_q, 1'b0};
    cost_dec  = ({1'b0, cur.c} > dec) ? cur.c - dec[CW-1:0] : '0;
    push_sum  = {2'b0, dcost_q} + {1'b0, step_q, 1'b0};
    push_cost = (push_sum > (CW+2)'({CW{1'b1}})) ? '1 : push_sum[CW-1:0];
    push_skip = (last.d > min_depth_q) && (last.c <= dcost_q);
    sort_swap = ((sa.d <= min_depth_q) && (sb.d > min_depth_q)) || (sa.c > sb.c);
    h_last    = h_q == HW'(HYP_DEPTH - 1);
    sort_last = (j_q == HW'(HYP_DEPTH - 1)) && (i_q == HW'(HYP_DEPTH - 2));
    cap_stk   = mem_rdata;
    if ((mem_rdata[0].d == '0) && !push_skip) begin
      cap_stk[HYP_DEPTH-1] = '{d: md_q, v: mv_q, c: push_cost};
    end
    sort_stk = stk_q;
    if (sort_swap) begin
      sort_stk[i_q] = sb;
      sort_stk[j_q] = sa;
    end
    for (int k = 0; k < HYP_DEPTH; k++) begin
      swept[k] = mem_rdata[k];
      if (mem_rdata[k].c > thr_q) begin
        swept[k].d = '0;
        swept[k].v = dsigma_q;
        swept[k].c = dcost_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (cnt_q == ROW_AW'(ROWS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.op)
            OP_FUSE:   state_d = on_map ? S_RD : S_IDLE;
            OP_READ:   state_d = (on_map && slot_ok) ? S_RD : S_IDLE;
            OP_REJECT: state_d = S_SW_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_RD: state_d = S_CAP;
      S_CAP: begin
        if (op_q == OP_READ) begin
          state_d = S_IDLE;
        end else if (mem_rdata[0].d == '0) begin
          state_d = push_skip ? S_WB : S_SORT;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (cur.d == '0) state_d = S_SORT;
        else if (is_match && den != '0) state_d = S_MUL0;
        else if (h_last) state_d = S_SORT;
      end
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_DIV0S;
      S_DIV0S: state_d = S_DIV0W;
      S_DIV0W: if (div_res.done) state_d = S_DIV1S;
      S_DIV1S: state_d = S_DIV1W;
      S_DIV1W: if (div_res.done) state_d = h_last ? S_SORT : S_WALK;
      S_SORT:  if (sort_last) state_d = S_WB;
      S_WB:    state_d = S_IDLE;
      S_SW_RD: state_d = S_SW_WR;
      S_SW_WR: begin
        if (cnt_q == ROW_AW'(ROWS - 1)) state_d = S_IDLE;
        else state_d = S_SW_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = (state_q == S_IDLE) && out_free;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = row_q;
    mem_raddr  = row_q;
    mem_wdata  = stk_q;
    div_start  = 1'b0;
    div_num    = num_q;
    mul_a      = cur.v;
    mul_b      = mv_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
      end
      S_RD:    mem_re = 1'b1;
      S_WB:    mem_we = 1'b1;
      S_SW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_q;
      end
      S_SW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = swept;
      end
      S_MUL0: mul_a = cur.d;
      S_MUL1: begin
        mul_a = md_q;
        mul_b = cur.v;
      end
      S_DIV0S: div_start = 1'b1;
      S_DIV1S: begin
        div_start = 1'b1;
        div_num   = {1'b0, prod_q};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      min_depth_q <= '0;
      step_q      <= 16'd64;
      dcost_q     <= 16'd256;
      dsigma_q    <= 24'd4096;
      thr_q       <= 16'd1024;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR || state_q == S_SW_WR) cnt_q <= cnt_q + 1'b1;
      else if (state_q == S_IDLE) cnt_q <= '0;
      // present the result once the request is retired
      if ((state_q != S_IDLE) && (state_d == S_IDLE) && (state_q != S_CLEAR)) begin
        out_valid_q <= 1'b1;
      end else if (in_acc && (state_d == S_IDLE)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_MIN_DEPTH:     min_depth_q <= cfg_i.data;
          CFG_COST_STEP:     step_q      <= cfg_i.data[CW-1:0];
          CFG_DEFAULT_COST:  dcost_q     <= cfg_i.data[CW-1:0];
          CFG_DEFAULT_SIGMA: dsigma_q    <= cfg_i.data;
          CFG_REJECT_THR:    thr_q       <= cfg_i.data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_d == S_IDLE && state_q != S_IDLE && state_q != S_CLEAR) begin
      if (state_q == S_CAP) begin
        out_status_q <= ST_DONE;
        out_hyp_q    <= mem_rdata[slot_q];
      end else begin
        out_status_q <= status_q;
        out_hyp_q    <= res_q;
      end
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q      <= in_i.op;
          slot_q    <= in_i.hyp_slot[HW-1:0];
          md_q      <= in_i.meas_depth;
          mv_q      <= in_i.meas_var;
          row_q     <= in_row;
          res_q     <= '0;
          h_q       <= '0;
          matched_q <= 1'b0;
          status_q  <= (in_i.op == OP_REJECT) ? ST_DONE : ST_RANGE;
          if (state_d == S_IDLE) begin
            out_status_q <= ST_RANGE;
            out_hyp_q    <= '0;
          end
        end
      end
      S_CAP: begin
        stk_q <= cap_stk;
        i_q   <= '0;
        j_q   <= HW'(1);
        if (mem_rdata[0].d == '0) begin
          status_q <= ST_NEW;
        end else begin
          status_q <= ST_NOMATCH;
        end
      end
      S_WALK: begin
        if (cur.d != '0) begin
          if (is_match) begin
            matched_q      <= 1'b1;
            status_q       <= ST_DONE;
            stk_q[h_q].c   <= cost_dec;
            den_q          <= den;
            if (den == '0 && !h_last) h_q <= h_q + 1'b1;
          end else begin
            stk_q[h_q].c <= cost_sat;
            if (!h_last) h_q <= h_q + 1'b1;
          end
        end
      end
      S_MUL0: prod_q <= mul_a * mul_b;
      S_MUL1: begin
        num_q  <= {1'b0, prod_q};
        prod_q <= mul_a * mul_b;
      end
      S_MUL2: begin
        num_q  <= num_q + {1'b0, prod_q};
        prod_q <= mul_a * mul_b;
      end
      S_DIV0W: if (div_res.done) stk_q[h_q].d <= div_res.quo[DW-1:0];
      S_DIV1W: begin
        if (div_res.done) begin
          stk_q[h_q].v <= div_res.quo[DW-1:0];
          if (!h_last) h_q <= h_q + 1'b1;
        end
      end
      S_SORT: begin
        stk_q <= sort_stk;
        if (j_q == HW'(HYP_DEPTH - 1)) begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + HW'(2);
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_depth = out_hyp_q.d;
  assign out_o.read_var   = out_hyp_q.v;
  assign out_o.read_cost  = out_hyp_q.c;

  `HDSF_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_start, !in_i.ready, "taken while busy")
  `HDSF_ASSERT_IMP(a_clr, clk_i, rst_ni, state_q == S_CLEAR, !out_o.valid, "early result")
  `HDSF_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, state_q == S_IDLE, !mem_we, "write in idle")

endmodule

`default_nettype wire

>>> bench/hdsf_checker.sv
// ----------------------------------------------------------------------------
// hdsf_checker
// Watches the request, result and register channels of the hypothesis stack,
// keeps its own copy of the store and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdsf_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hdsf_in_if   req_mon,
  hdsf_out_if  res_mon,
  hdsf_cfg_if  cfg_mon,
  output int   errors_o,
  output int   pending_o
);
  import hdsf_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] depth;
    logic [23:0] var_q;
    logic [15:0] cost;
  } answer_t;

  answer_t     answers_due[$];
  hyp_t        stack_mem[int unsigned];
  hyp_t        work[HYP_DEPTH];
  logic [23:0] min_depth_r, sigma_r;
  logic [15:0] step_r, def_cost_r, thr_r;

  assign pending_o = answers_due.size();

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic int unsigned slot_key(int unsigned x, int unsigned y, int unsigned h);
    return h * ROWS + y * MAP_WIDTH + x;
  endfunction

  function automatic void load_stack(int unsigned x, int unsigned y);
    for (int h = 0; h < HYP_DEPTH; h++) begin
      work[h] = stack_mem.exists(slot_key(x, y, h)) ? stack_mem[slot_key(x, y, h)] : '0;
    end
  endfunction

  function automatic void save_stack(int unsigned x, int unsigned y);
    for (int h = 0; h < HYP_DEPTH; h++) stack_mem[slot_key(x, y, h)] = work[h];
  endfunction

  // swap a pair when the first is invalid and the second valid, or the first costs more
  function automatic void order_stack();
    hyp_t t;
    for (int i = 0; i + 1 < HYP_DEPTH; i++) begin
      for (int j = i + 1; j < HYP_DEPTH; j++) begin
        if ((work[i].d <= min_depth_r && work[j].d > min_depth_r) || work[i].c > work[j].c) begin
          t = work[i]; work[i] = work[j]; work[j] = t;
        end
      end
    end
  endfunction

  function automatic logic [1:0] fuse_measurement(int unsigned x, int unsigned y,
                                                  logic [23:0] d, logic [23:0] v);
    bit              matched;
    logic [23:0]     delta;
    longint unsigned den, num, dec, c;
    matched = 0;
    load_stack(x, y);
    if (work[0].d == 0) begin
      if (!(work[HYP_DEPTH-1].d > min_depth_r && work[HYP_DEPTH-1].c <= def_cost_r)) begin
        c = longint'(def_cost_r) + 2 * longint'(step_r);
        work[HYP_DEPTH-1].d = d;
        work[HYP_DEPTH-1].v = v;
        work[HYP_DEPTH-1].c = (c > 65535) ? 16'hFFFF : c[15:0];
        order_stack();
        save_stack(x, y);
      end
      return ST_NEW;
    end
    for (int h = 0; h < HYP_DEPTH; h++) begin
      if (work[h].d == 0) break;
      delta = (work[h].d > d) ? work[h].d - d : d - work[h].d;
      if (!matched && (delta < work[h].v || delta < v)) begin
        den = longint'(work[h].v) + longint'(v);
        dec = 2 * longint'(step_r);
        if (den != 0) begin
          num = longint'(work[h].d) * longint'(v) + longint'(d) * longint'(work[h].v);
          num = num / den;
          work[h].d = num[23:0];
          num = (longint'(work[h].v) * longint'(v)) / den;
          work[h].v = num[23:0];
        end
        work[h].c = (work[h].c > dec) ? work[h].c - dec[15:0] : 16'd0;
        matched = 1;
      end else begin
        c = longint'(work[h].c) + longint'(step_r);
        work[h].c = (c > 65535) ? 16'hFFFF : c[15:0];
      end
    end
    order_stack();
    save_stack(x, y);
    return matched ? ST_DONE : ST_NOMATCH;
  endfunction

  function automatic answer_t predict_request();
    answer_t     a;
    bit          on_map;
    int unsigned k;
    a = '0;
    a.status = ST_RANGE;
    on_map = req_mon.pix_x < MAP_WIDTH && req_mon.pix_y < MAP_HEIGHT;
    case (req_mon.op)
      OP_FUSE: begin
        if (on_map) a.status = fuse_measurement(req_mon.pix_x, req_mon.pix_y,
                                                req_mon.meas_depth, req_mon.meas_var);
      end
      OP_READ: begin
        if (on_map && req_mon.hyp_slot < HYP_DEPTH) begin
          k = slot_key(req_mon.pix_x, req_mon.pix_y, req_mon.hyp_slot);
          if (stack_mem.exists(k)) begin
            a.depth = stack_mem[k].d;
            a.var_q = stack_mem[k].v;
            a.cost  = stack_mem[k].c;
          end
          a.status = ST_DONE;
        end
      end
      OP_REJECT: begin
        // untouched entries have zero cost and never exceed the threshold
        foreach (stack_mem[i]) begin
          if (stack_mem[i].c > thr_r) stack_mem[i] = '{d: '0, v: sigma_r, c: def_cost_r};
        end
        a.status = ST_DONE;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      answers_due.delete();
      stack_mem.delete();
      errors_o    = 0;
      min_depth_r = '0;
      step_r      = 16'd64;
      def_cost_r  = 16'd256;
      sigma_r     = 24'd4096;
      thr_r       = 16'd1024;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MIN_DEPTH:     min_depth_r = cfg_mon.data;
          CFG_COST_STEP:     step_r      = cfg_mon.data[15:0];
          CFG_DEFAULT_COST:  def_cost_r  = cfg_mon.data[15:0];
          CFG_DEFAULT_SIGMA: sigma_r     = cfg_mon.data;
          CFG_REJECT_THR:    thr_r       = cfg_mon.data[15:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected result", res_mon.status, 0);
        end else begin
          want = answers_due.pop_front();
          if (res_mon.status !== want.status) report("status", res_mon.status, want.status);
          if (res_mon.read_depth !== want.depth) report("depth", res_mon.read_depth, want.depth);
          if (res_mon.read_var !== want.var_q) report("variance", res_mon.read_var, want.var_q);
          if (res_mon.read_cost !== want.cost) report("cost", res_mon.read_cost, want.cost);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        answers_due.insert(answers_due.size(), predict_request());
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and register writes into the hypothesis stack with random
// idling and a long result hold-off; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hdsf_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int POOL = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 0;
  bit   hold_req = 0;
  int   hold_left = 0;
  int   errors, pending;

  logic [7:0]  pool_x[POOL] = '{8'd0, 8'd127, 8'd5, 8'd64, 8'd0, 8'd100};
  logic [7:0]  pool_y[POOL] = '{8'd0, 8'd127, 8'd9, 8'd3, 8'd127, 8'd77};
  logic [23:0] pool_depth[POOL];

  hdsf_in_if  req_ch();
  hdsf_out_if res_ch();
  hdsf_cfg_if cfg_ch();

  depth_hypothesis_stack_fusion uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (res_ch),
    .cfg_i (cfg_ch)
  );

  hdsf_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_mon  (req_ch),
    .res_mon  (res_ch),
    .cfg_mon  (cfg_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else begin
        res_ch.ready = calm || $urandom_range(0, 99) >= 29;
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [7:0] x, logic [7:0] y, logic [2:0] slot,
                          logic [23:0] d, logic [23:0] v);
    while (!calm && $urandom_range(0, 99) < 29) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      = 1'b1;
    req_ch.op         = op;
    req_ch.pix_x      = x;
    req_ch.pix_y      = y;
    req_ch.hyp_slot   = slot;
    req_ch.meas_depth = d;
    req_ch.meas_var   = v;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic configure(logic [23:0] min_d, logic [15:0] step, logic [15:0] def_c,
                           logic [23:0] sigma, logic [15:0] thr);
    drain();
    write_reg(CFG_MIN_DEPTH, min_d);
    write_reg(CFG_COST_STEP, {8'd0, step});
    write_reg(CFG_DEFAULT_COST, {8'd0, def_c});
    write_reg(CFG_DEFAULT_SIGMA, sigma);
    write_reg(CFG_REJECT_THR, {8'd0, thr});
  endtask

  // mostly a few busy pixels with measurements near a per-pixel depth
  task automatic random_req();
    int          p, pick;
    logic [1:0]  op;
    logic [7:0]  x, y;
    logic [2:0]  slot;
    logic [23:0] d, v;
    p    = $urandom_range(0, POOL - 1);
    pick = $urandom_range(0, 999);
    x    = pool_x[p];
    y    = pool_y[p];
    if (pick < 40) begin
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
    end else if (pick < 90) begin
      x = 8'($urandom_range(0, MAP_WIDTH - 1));
      y = 8'($urandom_range(0, MAP_HEIGHT - 1));
    end
    pick = $urandom_range(0, 999);
    if (pick < 5)        op = OP_REJECT;
    else if (pick < 25)  op = OP_SPARE;
    else if (pick < 380) op = OP_READ;
    else                 op = OP_FUSE;
    slot = 3'(($urandom_range(0, 9) < 8) ? $urandom_range(0, HYP_DEPTH - 1)
                                         : $urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) begin
      d = 24'($urandom());
      v = 24'($urandom());
    end else begin
      v = 24'($urandom_range(0, 4096));
      d = 24'(32'(pool_depth[p]) + $urandom_range(0, 8000) - 32'd4000);
    end
    send_req(op, x, y, slot, d, v);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_READ;
    req_ch.pix_x = '0;
    req_ch.pix_y = '0;
    req_ch.hyp_slot = '0;
    req_ch.meas_depth = '0;
    req_ch.meas_var = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIN_DEPTH;
    cfg_ch.data = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    configure(24'd0, 16'd64, 16'd256, 24'd4096, 16'd1024);
    // directed: empty reads, push, match, mismatch, full stack, ranges
    send_req(OP_READ, 8'd3, 8'd3, 3'd0, '0, '0);
    send_req(OP_FUSE, 8'd3, 8'd3, 3'd0, 24'h010000, 24'h000800);
    send_req(OP_FUSE, 8'd3, 8'd3, 3'd0, 24'h010400, 24'h000800);
    send_req(OP_FUSE, 8'd3, 8'd3, 3'd0, 24'h050000, 24'h000100);
    send_req(OP_FUSE, 8'd3, 8'd3, 3'd0, 24'h090000, 24'h000100);
    send_req(OP_FUSE, 8'd3, 8'd3, 3'd0, 24'hFFFFFF, 24'hFFFFFF);
    for (int s = 0; s < 8; s++) send_req(OP_READ, 8'd3, 8'd3, s[2:0], '0, '0);
    send_req(OP_FUSE, 8'd4, 8'd3, 3'd0, 24'd0, 24'd0);
    send_req(OP_FUSE, 8'd4, 8'd3, 3'd0, 24'd0, 24'd0);
    send_req(OP_FUSE, 8'd128, 8'd3, 3'd0, 24'h1000, 24'h10);
    send_req(OP_FUSE, 8'd3, 8'd255, 3'd0, 24'h1000, 24'h10);
    send_req(OP_READ, 8'd255, 8'd0, 3'd1, '0, '0);
    send_req(OP_SPARE, 8'd3, 8'd3, 3'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_req(OP_REJECT, 8'd0, 8'd0, 3'd0, '0, '0);
    send_req(OP_READ, 8'd3, 8'd3, 3'd3, '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(24'd0, 16'd64, 16'd256, 24'd4096, 16'd1024);
        1: configure(24'h000800, 16'hFFFF, 16'hFFFF, 24'd0, 16'd0);
        2: configure(24'hFFFFFF, 16'd0, 16'd0, 24'hFFFFFF, 16'hFFFF);
        default: configure(24'($urandom()), 16'($urandom_range(1, 700)),
                           16'($urandom_range(0, 2000)), 24'($urandom()),
                           16'($urandom_range(200, 4000)));
      endcase
      foreach (pool_depth[i]) pool_depth[i] = 24'($urandom_range(24'h004000, 24'hF00000));
      if (phase == 1) hold_req = 1;
      for (int n = 0; n < 385; n++) begin
        calm = (phase == 2 && n < 150);
        random_req();
      end
      calm = 0;
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
